/* hw/rtl/tbrl_pkg.sv */
// Shared types, constants and helpers for the token bucket request limiter.
`timescale 1ns / 1ps
`default_nettype none

package tbrl_pkg;

   // Field widths fixed by the interface.
   localparam int WORD_W      = 32;
   localparam int INDEX_W     = 8;
   localparam int INDEX_DEPTH = 2 ** INDEX_W;

   // Default bucket count.
   localparam int NUM_BUCKETS_DEFAULT = 256;

   // Control register map.
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUCKET_CAPACITY   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOKENS_PER_SECOND = 1'd1;

   // Register values after reset.
   localparam logic [WORD_W-1:0] CAPACITY_RESET = 32'd10;
   localparam logic [WORD_W-1:0] RATE_RESET     = 32'd1;

   // One stored bucket: token count and time of the last refill.
   typedef struct packed {
      logic [WORD_W-1:0] tokens;
      logic [WORD_W-1:0] refill_time;
   } bucket_entry_type;

   // Stage controls from the sequencer to the refill datapath.
   typedef struct packed {
      logic load_entry;
      logic load_gain;
      logic fwd_hit;
   } step_ctrl_type;

   // One result word.
   typedef struct packed {
      logic              allowed;
      logic [WORD_W-1:0] tokens_left;
      logic [WORD_W-1:0] retry_seconds;
   } rsp_word_type;

   // Address width for a store of the given depth.
   function automatic int addr_width(input int depth);
      int result;
      result = (depth > 1) ? $clog2(depth) : 1;
      return result;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/token_bucket_request_limiter.sv */
// Top level of the token bucket request limiter: sequencer, registers, result word.
//
// Usage: a request word (bucket index, current time in seconds) enters on the
// req_ channel when req_valid is high and req_stall is low. Each request gives
// exactly one result word on the rsp_ channel: allowed, tokens left and seconds
// until the next refill. Bucket indexes wrap modulo the bucket count.
// A request passes the read, gain and final states; its result is registered as
// it leaves the final state, and a new request is taken only then or while idle.
// Each request is a read, a gain multiply and a clamp-and-write-back of its
// bucket entry; the next request's memory read overlaps the write-back, and a
// same-bucket follow-up takes the written entry from a bypass register.
// Reset clears every bucket's in-use flag, loads capacity 10 and rate 1, and
// empties the result register; no clearing pass is needed.
// When the receiver stalls, the result word holds; one more request can reach
// its final stage, after which req_stall stays high until the word is taken.
// The csr_ port writes bucket_capacity (index 0) and tokens_per_second
// (index 1) and must only be used while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none

module token_bucket_request_limiter #(
   parameter int NUM_BUCKETS = tbrl_pkg::NUM_BUCKETS_DEFAULT
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire  [tbrl_pkg::INDEX_W-1:0]       req_bucket_index,
   input  wire  [tbrl_pkg::WORD_W-1:0]        req_now_seconds,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic                               rsp_allowed,
   output logic [tbrl_pkg::WORD_W-1:0]        rsp_tokens_left,
   output logic [tbrl_pkg::WORD_W-1:0]        rsp_retry_seconds,
   input  wire                                csr_write_enable,
   input  wire  [tbrl_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [tbrl_pkg::WORD_W-1:0]        csr_write_data
);
   import tbrl_pkg::*;

   // Only the first INDEX_DEPTH buckets can be reached by an index.
   localparam int SLOTS  = (NUM_BUCKETS < INDEX_DEPTH) ? NUM_BUCKETS : INDEX_DEPTH;
   localparam int SLOT_W = addr_width(SLOTS);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_GAIN,
      S_FINAL
   } state_type;

   state_type          state_ff;
   state_type          state_in;
   logic [WORD_W-1:0]  capacity_ff;
   logic [WORD_W-1:0]  rate_ff;
   logic [SLOT_W-1:0]  slot_lut [INDEX_DEPTH];
   logic [SLOT_W-1:0]  req_slot;
   logic [SLOT_W-1:0]  slot_ff;
   logic [WORD_W-1:0]  now_ff;
   logic               fwd_hit_ff;
   bucket_entry_type   fwd_entry_ff;
   logic               rsp_valid_ff;
   rsp_word_type       rsp_word_ff;
   logic               out_free;
   logic               finish;
   logic               req_accept;
   step_ctrl_type      ctrl;
   bucket_entry_type   mem_entry;
   logic               mem_used;
   rsp_word_type       result;
   bucket_entry_type   wb_entry;

   // Index to bucket slot: constant table of index modulo the bucket count.
   for (genvar i = 0; i < INDEX_DEPTH; i++) begin : g_slot
      assign slot_lut[i] = SLOT_W'(i % NUM_BUCKETS);
   end
   assign req_slot = slot_lut[req_bucket_index];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         rate_ff     <= RATE_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BUCKET_CAPACITY:   capacity_ff <= csr_write_data;
            CSR_TOKENS_PER_SECOND: rate_ff     <= csr_write_data;
            default:               ;
         endcase
      end
   end

   // Handshake: a new word is taken when idle or when the current one retires.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = (state_ff == S_FINAL) && out_free;
   assign req_stall  = !((state_ff == S_IDLE) || finish);
   assign req_accept = req_valid && !req_stall;

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  state_in = req_accept ? S_READ : S_IDLE;
         S_READ:  state_in = S_GAIN;
         S_GAIN:  state_in = S_FINAL;
         S_FINAL: begin
            if (finish) begin
               state_in = req_accept ? S_READ : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Sequencer state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_accept) begin
            fwd_hit_ff <= finish && (req_slot == slot_ff);
         end
      end
   end

   // Request fields, bypass entry and result word.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         slot_ff <= req_slot;
         now_ff  <= req_now_seconds;
      end
      if (finish) begin
         fwd_entry_ff <= wb_entry;
         rsp_word_ff  <= result;
      end
   end

   assign ctrl.load_entry = state_ff == S_READ;
   assign ctrl.load_gain  = state_ff == S_GAIN;
   assign ctrl.fwd_hit    = fwd_hit_ff;

   tbrl_bucket_store #(
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_accept),
      .rd_addr  (req_slot),
      .rd_entry (mem_entry),
      .rd_used  (mem_used),
      .wr_en    (finish),
      .wr_addr  (slot_ff),
      .wr_entry (wb_entry)
   );

   tbrl_refill_unit u_refill (
      .clock       (clock),
      .ctrl        (ctrl),
      .mem_entry   (mem_entry),
      .mem_used    (mem_used),
      .fwd_entry   (fwd_entry_ff),
      .capacity    (capacity_ff),
      .rate        (rate_ff),
      .now_seconds (now_ff),
      .result      (result),
      .wb_entry    (wb_entry)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_allowed       = rsp_word_ff.allowed;
   assign rsp_tokens_left   = rsp_word_ff.tokens_left;
   assign rsp_retry_seconds = rsp_word_ff.retry_seconds;

endmodule

`default_nettype wire

/* hw/rtl/tbrl_bucket_store.sv */
// Bucket memory with a registered read port and per-entry in-use flags.
`timescale 1ns / 1ps
`default_nettype none

module tbrl_bucket_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         rd_en,
   input  wire  [ADDR_W-1:0]           rd_addr,
   output tbrl_pkg::bucket_entry_type  rd_entry,
   output logic                        rd_used,
   input  wire                         wr_en,
   input  wire  [ADDR_W-1:0]           wr_addr,
   input  tbrl_pkg::bucket_entry_type  wr_entry
);
   import tbrl_pkg::*;

   bucket_entry_type mem [DEPTH];
   bucket_entry_type rd_entry_ff;
   logic             rd_used_ff;
   logic [DEPTH-1:0] in_use_ff;

   // Storage array: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rd_entry_ff <= mem[rd_addr];
      end
   end

   // In-use flags are cleared by reset and set on every write.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         rd_used_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            in_use_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_used_ff <= in_use_ff[rd_addr];
         end
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_used  = rd_used_ff;

endmodule

`default_nettype wire

/* hw/rtl/tbrl_refill_unit.sv */
// Refill datapath: elapsed time, token gain, clamp, take and retry delay.
`timescale 1ns / 1ps
`default_nettype none

module tbrl_refill_unit (
   input  wire                               clock,
   input  tbrl_pkg::step_ctrl_type           ctrl,
   input  tbrl_pkg::bucket_entry_type        mem_entry,
   input  wire                               mem_used,
   input  tbrl_pkg::bucket_entry_type        fwd_entry,
   input  wire  [tbrl_pkg::WORD_W-1:0]       capacity,
   input  wire  [tbrl_pkg::WORD_W-1:0]       rate,
   input  wire  [tbrl_pkg::WORD_W-1:0]       now_seconds,
   output tbrl_pkg::rsp_word_type            result,
   output tbrl_pkg::bucket_entry_type        wb_entry
);
   import tbrl_pkg::*;

   bucket_entry_type    base;
   logic                fresh;
   logic [WORD_W-1:0]   held_in;
   logic [WORD_W-1:0]   last_in;
   logic                moved;
   logic [WORD_W-1:0]   held_ff;
   logic [WORD_W-1:0]   last_ff;
   logic [WORD_W-1:0]   elapsed_ff;
   logic [WORD_W-1:0]   refill_at_ff;
   logic [2*WORD_W-1:0] gain_in;
   logic [2*WORD_W-1:0] gain_ff;
   logic [WORD_W:0]     next_tick;
   logic [WORD_W:0]     now_ext;
   logic [WORD_W-1:0]   retry_in;
   logic [WORD_W-1:0]   retry_ff;
   logic                over;
   logic [WORD_W:0]     sum;
   logic [WORD_W-1:0]   level;
   logic                allowed;
   logic [WORD_W-1:0]   taken;

   // Entry select: a just-written entry wins over the memory; an unused
   // bucket starts full with its refill time at now.
   always_comb begin
      base    = ctrl.fwd_hit ? fwd_entry : mem_entry;
      fresh   = !(ctrl.fwd_hit || mem_used);
      held_in = fresh ? capacity : base.tokens;
      last_in = fresh ? now_seconds : base.refill_time;
      moved   = now_seconds > last_in;
   end

   // Read stage: elapsed seconds and the new refill time.
   always_ff @(posedge clock) begin
      if (ctrl.load_entry) begin
         held_ff      <= held_in;
         last_ff      <= last_in;
         elapsed_ff   <= moved ? (now_seconds - last_in) : '0;
         refill_at_ff <= moved ? now_seconds : last_in;
      end
   end

   // Gain and retry stage.
   assign gain_in   = (2*WORD_W)'(rate) * (2*WORD_W)'(elapsed_ff);
   assign next_tick = {1'b0, refill_at_ff} + (WORD_W+1)'(1);
   assign now_ext   = {1'b0, now_seconds};
   assign retry_in  = (next_tick > now_ext) ? WORD_W'(next_tick - now_ext) : '0;

   always_ff @(posedge clock) begin
      if (ctrl.load_gain) begin
         gain_ff  <= gain_in;
         retry_ff <= retry_in;
      end
   end

   // Final stage: saturate at capacity, then take one token if there is one.
   always_comb begin
      over    = (gain_ff[2*WORD_W-1:WORD_W] != '0) || (gain_ff[WORD_W-1:0] >= capacity);
      sum     = {1'b0, held_ff} + {1'b0, gain_ff[WORD_W-1:0]};
      level   = (over || (sum > {1'b0, capacity})) ? capacity : sum[WORD_W-1:0];
      allowed = level != '0;
      taken   = level - WORD_W'(1);
   end

   // A refused request leaves the bucket as it was read.
   assign wb_entry.tokens      = allowed ? taken : held_ff;
   assign wb_entry.refill_time = allowed ? refill_at_ff : last_ff;

   assign result.allowed       = allowed;
   assign result.tokens_left   = allowed ? taken : '0;
   assign result.retry_seconds = retry_ff;

endmodule

`default_nettype wire

/* hw/rtl/tbrl_checker.sv */
// Port-level checks for the token bucket request limiter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module tbrl_checker (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_valid,
   input wire                               req_stall,
   input wire                               rsp_valid,
   input wire                               rsp_stall,
   input wire                               rsp_allowed,
   input wire [tbrl_pkg::WORD_W-1:0]        rsp_tokens_left,
   input wire [tbrl_pkg::WORD_W-1:0]        rsp_retry_seconds
);
   import tbrl_pkg::*;

   logic req_take;
   assign req_take = req_valid && !req_stall;

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_allowed)
         && $stable(rsp_tokens_left) && $stable(rsp_retry_seconds))
      else $error("stalled result word changed");

   // A refused request reports no tokens left.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_allowed |-> rsp_tokens_left == '0)
      else $error("refused request reports tokens");

   // A taken request is followed by no other while it is in its read and gain states.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_take ##1 !req_take)
      else $error("requests taken too close together");

   // A freshly raised result valid matches a request taken earlier, which has passed
   // through the read, gain and final states. The request is sampled at its
   // accepting edge.
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_take, 4))
      else $error("result without a matching request");

endmodule

bind token_bucket_request_limiter tbrl_checker u_tbrl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_allowed       (rsp_allowed),
   .rsp_tokens_left   (rsp_tokens_left),
   .rsp_retry_seconds (rsp_retry_seconds)
);

`default_nettype wire
